// File: rtl/core/pstt_pkg.sv
package pstt_pkg;

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_ADD   = 3'd1;
    localparam logic [2:0] ACT_DEL   = 3'd2;
    localparam logic [2:0] ACT_QUERY = 3'd3;
    localparam logic [2:0] ACT_POLL  = 3'd4;

    localparam int SUB_W     = 13;
    localparam int M20_W     = 5;
    localparam int M100_W    = 7;
    localparam logic [SUB_W-1:0]  SUB_WRAP = 13'd6000;
    localparam logic [M20_W-1:0]  M20_TOP  = 5'd19;
    localparam logic [M100_W-1:0] M100_TOP = 7'd99;

    typedef struct packed {
        logic [2:0]  action;
        logic [1:0]  slot;
        logic [31:0] timeout;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  slot_out;
        logic        expired;
        logic        armed;
        logic [31:0] tick_now;
        logic        pulse_base;
        logic        pulse_twenty;
        logic        pulse_hundred;
        logic        pulse_wrap;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic base;
        logic twenty;
        logic hundred;
        logic wrap;
    } t_pulse;

endpackage

// File: rtl/core/pstt_tick.sv
module pstt_tick (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    output logic [31:0]         o_tick,
    output logic [31:0]         o_tick_inc,
    output pstt_pkg::t_pulse    o_pulse
);

    logic [31:0]                       r_tick;
    logic [pstt_pkg::SUB_W-1:0]        r_sub;
    logic [pstt_pkg::M20_W-1:0]        r_m20;
    logic [pstt_pkg::M100_W-1:0]       r_m100;
    logic [pstt_pkg::SUB_W-1:0]        n_sub;
    logic [pstt_pkg::M20_W-1:0]        n_m20;
    logic [pstt_pkg::M100_W-1:0]       n_m100;

    always_comb begin
        n_sub  = r_sub + 1'b1;
        n_m20  = (r_m20 == pstt_pkg::M20_TOP) ? '0 : r_m20 + 1'b1;
        n_m100 = (r_m100 == pstt_pkg::M100_TOP) ? '0 : r_m100 + 1'b1;
    end

    assign o_tick            = r_tick;
    assign o_tick_inc        = r_tick + 32'd1;
    assign o_pulse.base      = 1'b1;
    assign o_pulse.twenty    = (n_m20 == '0);
    assign o_pulse.hundred   = (n_m100 == '0);
    assign o_pulse.wrap      = (n_sub == pstt_pkg::SUB_WRAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= '0;
            r_sub  <= '0;
            r_m20  <= '0;
            r_m100 <= '0;
        end else if (i_adv) begin
            r_tick <= o_tick_inc;
            r_sub  <= (n_sub == pstt_pkg::SUB_WRAP) ? '0 : n_sub;
            r_m20  <= n_m20;
            r_m100 <= n_m100;
        end
    end

endmodule

// File: rtl/core/periodic_soft_timer_table_top.sv
// Periodic timer table with a tick base.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one action per
// item: tick, add slot, delete slot, query slot or poll all slots.
// Output channel (o_out_valid / i_out_stall / o_out_item) returns results;
// the final result of an item carries last.
// Tick, add, delete and query give one result: the item is registered, and
// its result is loaded into the output register once that register is free;
// no new item is taken until then, so these items never overlap.
// Poll walks the slot table held in a one-port-read memory, one slot per
// cycle unless paused for the output (see below); each expired slot gives a result.
// Unused action codes are taken and dropped with no result.
// A stalled receiver holds the output register; the walk pauses only when it
// has a second result to emit while the first still waits.
// Reset is synchronous: it clears the tick count, sub-counter, armed bits and
// output valid; the slot memory needs no clearing since disarmed slots are
// never read for results.
module periodic_soft_timer_table_top #(
    parameter int NUM_SLOTS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pstt_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pstt_pkg::t_out_item o_out_item
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ONE  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]               r_state, n_state;
    pstt_pkg::t_in_item       r_item, n_item;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]         r_pend_idx, n_pend_idx;
    logic [NUM_SLOTS-1:0]     r_armed, n_armed;
    logic                     r_out_valid;
    pstt_pkg::t_out_item      r_out;

    logic [63:0]              r_mem [NUM_SLOTS];
    logic [63:0]              r_rd;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [63:0]              mem_wdata;

    logic                     out_free;
    logic                     emit;
    pstt_pkg::t_out_item      emit_item;
    logic                     tick_adv;
    logic [31:0]              tick;
    logic [31:0]              tick_inc;
    pstt_pkg::t_pulse         pulse;
    logic                     slot_ok;
    logic [IDX_W-1:0]         slot_addr;
    logic [31:0]              elapsed;
    logic                     hit;

    pstt_tick u_tick (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (tick_adv),
        .o_tick     (tick),
        .o_tick_inc (tick_inc),
        .o_pulse    (pulse)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign slot_ok    = (32'(r_item.slot) < NUM_SLOTS);
    assign slot_addr  = IDX_W'(r_item.slot);
    assign elapsed    = tick - r_rd[31:0];
    assign hit        = r_armed[r_idx] && (elapsed >= r_rd[63:32]);
    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_idx        = r_idx;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        n_armed      = r_armed;
        emit         = 1'b0;
        emit_item    = '0;
        emit_item.tick_now = tick;
        mem_we       = 1'b0;
        mem_waddr    = r_idx;
        mem_wdata    = {r_rd[63:32], tick};
        tick_adv     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_item;
                    unique case (i_in_item.action)
                        pstt_pkg::ACT_TICK, pstt_pkg::ACT_ADD,
                        pstt_pkg::ACT_DEL, pstt_pkg::ACT_QUERY: begin
                            n_state = S_ONE;
                        end
                        pstt_pkg::ACT_POLL: begin
                            n_state      = S_CHK;
                            n_idx        = '0;
                            n_pend_valid = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ONE: begin
                if (out_free) begin
                    emit           = 1'b1;
                    n_state        = S_IDLE;
                    emit_item.last = 1'b1;
                    unique case (r_item.action)
                        pstt_pkg::ACT_TICK: begin
                            tick_adv                = 1'b1;
                            emit_item.tick_now      = tick_inc;
                            emit_item.pulse_base    = pulse.base;
                            emit_item.pulse_twenty  = pulse.twenty;
                            emit_item.pulse_hundred = pulse.hundred;
                            emit_item.pulse_wrap    = pulse.wrap;
                        end
                        pstt_pkg::ACT_ADD: begin
                            emit_item.slot_out = r_item.slot;
                            emit_item.armed    = slot_ok;
                            if (slot_ok) begin
                                mem_we             = 1'b1;
                                mem_waddr          = slot_addr;
                                mem_wdata          = {r_item.timeout, tick};
                                n_armed[slot_addr] = 1'b1;
                            end
                        end
                        pstt_pkg::ACT_DEL: begin
                            emit_item.slot_out = r_item.slot;
                            if (slot_ok) begin
                                n_armed[slot_addr] = 1'b0;
                            end
                        end
                        default: begin
                            emit_item.slot_out = r_item.slot;
                            emit_item.armed    = slot_ok && r_armed[slot_addr];
                        end
                    endcase
                end
            end
            S_CHK: begin
                if (!(hit && r_pend_valid) || out_free) begin
                    if (hit) begin
                        mem_we       = 1'b1;
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_idx;
                        if (r_pend_valid) begin
                            emit               = 1'b1;
                            emit_item.slot_out = 2'(r_pend_idx);
                            emit_item.expired  = 1'b1;
                            emit_item.armed    = 1'b1;
                        end
                    end
                    if (r_idx == IDX_LAST) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                if (out_free) begin
                    emit           = 1'b1;
                    n_state        = S_IDLE;
                    emit_item.last = 1'b1;
                    if (r_pend_valid) begin
                        emit_item.slot_out = 2'(r_pend_idx);
                        emit_item.expired  = 1'b1;
                        emit_item.armed    = 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_valid <= 1'b0;
            r_armed      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_armed      <= n_armed;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        if (emit) begin
            r_out <= emit_item;
        end
    end

endmodule
